[rtl/srs_pkg.sv]
`timescale 1ns / 1ps
package srs_pkg;

    // Serial multiplier: signed operand widths and magnitude widths.
    localparam int A_W   = 44;
    localparam int B_W   = 35;
    localparam int MAG_A = 43;
    localparam int MAG_B = 34;
    localparam int P_W   = MAG_A + MAG_B + 1;

    // Accumulator for dot products and sums of squares.
    localparam int ACC_W = 72;

    // Square root unit: radicand and root widths.
    localparam int SQ_IN_W  = 72;
    localparam int SQ_OUT_W = 36;

    // Divider: numerator, divisor and quotient widths.
    localparam int DIV_N_W = 58;
    localparam int DIV_D_W = 36;
    localparam int DIV_Q_W = 25;

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_RULING_LENGTH  = 2'd0;
    localparam logic [1:0] REG_FLAT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_INDEX_MODULUS  = 2'd2;

    localparam logic [15:0] RL_RESET = 16'd256;
    localparam logic [14:0] FT_RESET = 15'd819;
    localparam logic [15:0] IM_RESET = 16'd1;

    // Vertex roles within a star.
    localparam logic [2:0] ROLE_CENTER = 3'd0;
    localparam logic [2:0] ROLE_XF     = 3'd1;
    localparam logic [2:0] ROLE_YF     = 3'd2;
    localparam logic [2:0] ROLE_XB     = 3'd3;
    localparam logic [2:0] ROLE_YB     = 3'd4;

    typedef struct packed {
        logic [2:0]         role;
        logic [15:0]        vertex_index;
        logic               on_boundary;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic               flat;
    } t_out_beat;

endpackage

[rtl/srs_mul.sv]
`timescale 1ns / 1ps
// Shift-and-add multiplier: one multiplier bit per cycle on magnitudes,
// the sign is applied to the finished product.
module srs_mul import srs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    output logic                  o_done,
    output logic signed [P_W-1:0] o_p
);
    localparam int CNT_W = $clog2(MAG_B + 1);

    logic [MAG_A-1:0] r_mc;
    logic [P_W-1:0]   r_p;
    logic [P_W-1:0]   n_p;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [A_W-1:0]   a_mag;
    logic [B_W-1:0]   b_mag;
    logic [MAG_A+1:0] sum;

    assign a_mag = i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
    assign b_mag = i_b[B_W-1] ? B_W'(-i_b) : B_W'(i_b);

    always_comb begin
        sum = {1'b0, r_p[P_W-1:MAG_B]} + (r_p[0] ? {2'b00, r_mc} : '0);
        n_p = {sum, r_p[MAG_B-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mc   <= a_mag[MAG_A-1:0];
                r_p    <= {{(MAG_A+1){1'b0}}, b_mag[MAG_B-1:0]};
                r_neg  <= i_a[A_W-1] ^ i_b[B_W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= n_p;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_B - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_neg ? -$signed(r_p) : $signed(r_p);

endmodule

[rtl/srs_sqrt.sv]
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per cycle.
module srs_sqrt import srs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_IN_W-1:0]  i_v,
    output logic                o_done,
    output logic [SQ_OUT_W-1:0] o_root
);
    localparam int CNT_W = $clog2(SQ_OUT_W + 1);
    localparam int REM_W = SQ_OUT_W + 4;

    logic [SQ_IN_W-1:0]  r_v;
    logic [REM_W-1:0]    r_rem;
    logic [SQ_OUT_W-1:0] r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [REM_W-1:0]    rem2;
    logic [REM_W-1:0]    trial;

    assign rem2  = {r_rem[SQ_OUT_W+1:0], r_v[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_v;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v <= {r_v[SQ_IN_W-3:0], 2'b00};
                if (rem2 >= trial) begin
                    r_rem  <= rem2 - trial;
                    r_root <= {r_root[SQ_OUT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem2;
                    r_root <= {r_root[SQ_OUT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[rtl/srs_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in DIV_Q_W bits.
module srs_div import srs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_done,
    output logic [DIV_Q_W-1:0] o_quo,
    output logic [DIV_N_W-1:0] o_rem
);
    localparam int D_W   = DIV_D_W + DIV_Q_W - 1;
    localparam int CMP_W = (D_W > DIV_N_W) ? D_W : DIV_N_W;
    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [DIV_N_W-1:0] r_rem;
    logic [D_W-1:0]     r_d;
    logic [DIV_Q_W-1:0] r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               fits;

    assign fits = CMP_W'(r_rem) >= CMP_W'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_d    <= {i_den, {(DIV_Q_W-1){1'b0}}};
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= DIV_N_W'(CMP_W'(r_rem) - CMP_W'(r_d));
                end
                r_q   <= {r_q[DIV_Q_W-2:0], fits};
                r_d   <= r_d >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule

[rtl/surface_ruling_segment.sv]
`timescale 1ns / 1ps
// Ruling segment of one quad-mesh star. The five vertices of a star come in
// one beat each, tagged by role (center, x forward, y forward, x back,
// y back). Center and forward/back beats only update the stored star. The
// y-back beat starts the computation: an index check by modulo, the
// back-normal flips, the flatness test, the cross product of the center
// normal with the summed differences, its norm, the forward edge length,
// the normalization and the offsets. All products go through one
// shift-and-add multiplier that retires one multiplier bit per cycle (31
// products at most), next to a one-bit-per-cycle square root (two roots
// of 36 bits) and a restoring divider (up to four divisions with 25-bit
// quotients). A y-back beat keeps the input side busy until the star is
// done; the path is shorter for a flat star, a zero cross product or a
// failed index check, and a boundary neighbor does not hold the input side
// at all. The finished segment sits in an output register, so the next
// star can start loading while it waits to be taken. Registers are written
// over the APB port at byte offsets 0 (ruling_length), 4 (flat_threshold)
// and 8 (index_modulus); an index_modulus of zero acts as one.
module surface_ruling_segment import srs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b1 << 0,
        S_MOD   = 15'b1 << 1,
        S_DOTX  = 15'b1 << 2,
        S_DOTY  = 15'b1 << 3,
        S_NRM   = 15'b1 << 4,
        S_DOTNN = 15'b1 << 5,
        S_CROSS = 15'b1 << 6,
        S_SQC   = 15'b1 << 7,
        S_SQRTC = 15'b1 << 8,
        S_SQE   = 15'b1 << 9,
        S_SQRTE = 15'b1 << 10,
        S_SCALE = 15'b1 << 11,
        S_DIVR  = 15'b1 << 12,
        S_OFF   = 15'b1 << 13,
        S_OUT   = 15'b1 << 14
    } t_state;

    function automatic logic signed [A_W-1:0] f_pick(
        input logic [1:0]            sel,
        input logic signed [A_W-1:0] v0,
        input logic signed [A_W-1:0] v1,
        input logic signed [A_W-1:0] v2
    );
        logic signed [A_W-1:0] res;
        case (sel)
            2'd0:    res = v0;
            2'd1:    res = v1;
            default: res = v2;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] f_sat(input logic signed [44:0] v);
        logic [31:0] res;
        if (v > 45'sd2147483647) begin
            res = 32'h7fff_ffff;
        end else if (v < -45'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [15:0] r_rl;
    logic [14:0] r_ft;
    logic [15:0] r_im;

    // Stored star.
    logic signed [15:0] r_cn [3];
    logic signed [15:0] r_xf [3];
    logic signed [15:0] r_yf [3];
    logic signed [15:0] r_xb [3];
    logic signed [15:0] r_yb [3];
    logic signed [31:0] r_cp [3];
    logic signed [31:0] r_fp [3];
    logic [15:0]        r_id;
    logic               r_bnd;

    // Working values of the y-back computation.
    logic signed [16:0] r_xbf [3];
    logic signed [16:0] r_ybf [3];
    logic signed [17:0] r_nx [3];
    logic signed [17:0] r_ny [3];
    logic signed [34:0] r_c [3];
    logic [SQ_OUT_W-1:0] r_cl;
    logic [SQ_OUT_W-1:0] r_el;
    logic [41:0]        r_scale;
    logic [DIV_Q_W-1:0] r_r [3];
    logic signed [43:0] r_off [3];
    logic               r_fx;
    logic               r_flat;
    logic signed [ACC_W-1:0] r_acc;

    // Sequencer.
    t_state     r_state;
    logic [2:0] r_k;
    logic       r_pend;
    t_out_beat  r_out;
    logic       r_out_valid;

    // Shared units.
    logic                  mul_go;
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic                  mul_done;
    logic signed [P_W-1:0] mul_p;
    logic                  div_go;
    logic [DIV_N_W-1:0]    div_num;
    logic [DIV_D_W-1:0]    div_den;
    logic                  div_done;
    logic [DIV_Q_W-1:0]    div_quo;
    logic [DIV_N_W-1:0]    div_rem;
    logic                  sq_go;
    logic                  sq_done;
    logic [SQ_OUT_W-1:0]   sq_root;

    logic signed [18:0]      s [3];
    logic signed [32:0]      e [3];
    logic [33:0]             cmag;
    logic                    c_zero;
    logic signed [ACC_W-1:0] prod_t;
    logic signed [ACC_W-1:0] acc_n;
    logic signed [ACC_W-1:0] t2;
    logic                    u_done;
    logic                    in_acc;
    logic                    cfg_wr;
    logic [15:0]             modv;
    logic signed [43:0]      om;

    assign pready     = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign modv       = (r_im == 16'd0) ? 16'd1 : r_im;

    always_comb begin
        case (paddr[3:2])
            REG_RULING_LENGTH:  prdata = {16'd0, r_rl};
            REG_FLAT_THRESHOLD: prdata = {17'd0, r_ft};
            REG_INDEX_MODULUS:  prdata = {16'd0, r_im};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = 19'(r_nx[i]) + 19'(r_ny[i]);
            e[i] = 33'(r_fp[i]) - 33'(r_cp[i]);
        end
    end

    assign c_zero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    assign t2     = ACC_W'({15'd0, r_ft} * {15'd0, r_ft});
    assign prod_t = ACC_W'(mul_p);
    assign acc_n  = ((r_state == S_CROSS) && r_k[0]) ? r_acc - prod_t : r_acc + prod_t;
    assign u_done = mul_done || div_done || sq_done;
    assign om     = 44'(mul_p >>> 24);

    // Operand selection for whichever unit the current step uses.
    always_comb begin
        logic signed [A_W-1:0] cpick;
        mul_go  = 1'b0;
        div_go  = 1'b0;
        sq_go   = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        cpick   = f_pick(r_k[1:0], A_W'(r_c[0]), A_W'(r_c[1]), A_W'(r_c[2]));
        cmag    = cpick[A_W-1] ? 34'(-cpick) : 34'(cpick);
        unique case (r_state)
            S_MOD: begin
                div_go  = !r_pend;
                div_num = DIV_N_W'(r_id);
                div_den = DIV_D_W'(modv);
            end
            S_DOTX: begin
                mul_go = !r_pend;
                mul_a  = f_pick(r_k[1:0], A_W'(r_xf[0]), A_W'(r_xf[1]), A_W'(r_xf[2]));
                mul_b  = B_W'(f_pick(r_k[1:0], A_W'(r_xb[0]), A_W'(r_xb[1]),
                                     A_W'(r_xb[2])));
            end
            S_DOTY: begin
                mul_go = !r_pend;
                mul_a  = f_pick(r_k[1:0], A_W'(r_yf[0]), A_W'(r_yf[1]), A_W'(r_yf[2]));
                mul_b  = B_W'(f_pick(r_k[1:0], A_W'(r_yb[0]), A_W'(r_yb[1]),
                                     A_W'(r_yb[2])));
            end
            S_NRM: begin
                mul_go = !r_pend;
                if (r_k < 3'd3) begin
                    mul_a = f_pick(r_k[1:0], A_W'(r_nx[0]), A_W'(r_nx[1]), A_W'(r_nx[2]));
                end else begin
                    mul_a = f_pick(2'(r_k - 3'd3), A_W'(r_ny[0]), A_W'(r_ny[1]),
                                   A_W'(r_ny[2]));
                end
                mul_b = B_W'(mul_a);
            end
            S_DOTNN: begin
                mul_go = !r_pend;
                mul_a  = f_pick(r_k[1:0], A_W'(r_ny[0]), A_W'(r_ny[1]), A_W'(r_ny[2]));
                mul_b  = B_W'(f_pick(r_k[1:0], A_W'(r_nx[0]), A_W'(r_nx[1]),
                                     A_W'(r_nx[2])));
            end
            S_CROSS: begin
                // Each component takes two products; odd ones are subtracted.
                mul_go = !r_pend;
                case (r_k)
                    3'd0:    begin mul_a = A_W'(r_cn[1]); mul_b = B_W'(s[2]); end
                    3'd1:    begin mul_a = A_W'(r_cn[2]); mul_b = B_W'(s[1]); end
                    3'd2:    begin mul_a = A_W'(r_cn[2]); mul_b = B_W'(s[0]); end
                    3'd3:    begin mul_a = A_W'(r_cn[0]); mul_b = B_W'(s[2]); end
                    3'd4:    begin mul_a = A_W'(r_cn[0]); mul_b = B_W'(s[1]); end
                    default: begin mul_a = A_W'(r_cn[1]); mul_b = B_W'(s[0]); end
                endcase
            end
            S_SQC: begin
                mul_go = !r_pend && !(c_zero && (r_k == 3'd0));
                mul_a  = cpick;
                mul_b  = B_W'(cpick);
            end
            S_SQRTC, S_SQRTE: begin
                sq_go = !r_pend;
            end
            S_SQE: begin
                mul_go = !r_pend;
                mul_a  = f_pick(r_k[1:0], A_W'(e[0]), A_W'(e[1]), A_W'(e[2]));
                mul_b  = B_W'(mul_a);
            end
            S_SCALE: begin
                mul_go = !r_pend;
                mul_a  = A_W'(r_el);
                mul_b  = B_W'(r_rl);
            end
            S_DIVR: begin
                div_go  = !r_pend;
                div_num = {cmag, 24'd0};
                div_den = r_cl;
            end
            S_OFF: begin
                mul_go = !r_pend;
                mul_a  = A_W'(r_scale);
                mul_b  = B_W'(f_pick(r_k[1:0], A_W'(r_r[0]), A_W'(r_r[1]), A_W'(r_r[2])));
            end
            default: begin
            end
        endcase
    end

    srs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    srs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    srs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_go),
        .i_v     (SQ_IN_W'(r_acc)),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl        <= RL_RESET;
            r_ft        <= FT_RESET;
            r_im        <= IM_RESET;
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_id        <= '0;
            r_bnd       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cn[i] <= '0;
                r_xf[i] <= '0;
                r_yf[i] <= '0;
                r_xb[i] <= '0;
                r_cp[i] <= '0;
                r_fp[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_RULING_LENGTH:  r_rl <= pwdata[15:0];
                    REG_FLAT_THRESHOLD: r_ft <= pwdata[14:0];
                    REG_INDEX_MODULUS:  r_im <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (mul_go || div_go || sq_go) begin
                r_pend <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.role)
                            ROLE_CENTER: begin
                                r_cn[0] <= i_in_data.normal_x;
                                r_cn[1] <= i_in_data.normal_y;
                                r_cn[2] <= i_in_data.normal_z;
                                r_cp[0] <= i_in_data.pos_x;
                                r_cp[1] <= i_in_data.pos_y;
                                r_cp[2] <= i_in_data.pos_z;
                                r_id    <= i_in_data.vertex_index;
                                r_bnd   <= 1'b0;
                            end
                            ROLE_XF: begin
                                r_xf[0] <= i_in_data.normal_x;
                                r_xf[1] <= i_in_data.normal_y;
                                r_xf[2] <= i_in_data.normal_z;
                                r_fp[0] <= i_in_data.pos_x;
                                r_fp[1] <= i_in_data.pos_y;
                                r_fp[2] <= i_in_data.pos_z;
                                r_bnd   <= r_bnd || i_in_data.on_boundary;
                            end
                            ROLE_YF: begin
                                r_yf[0] <= i_in_data.normal_x;
                                r_yf[1] <= i_in_data.normal_y;
                                r_yf[2] <= i_in_data.normal_z;
                                r_bnd   <= r_bnd || i_in_data.on_boundary;
                            end
                            ROLE_XB: begin
                                r_xb[0] <= i_in_data.normal_x;
                                r_xb[1] <= i_in_data.normal_y;
                                r_xb[2] <= i_in_data.normal_z;
                                r_bnd   <= r_bnd || i_in_data.on_boundary;
                            end
                            ROLE_YB: begin
                                r_yb[0] <= i_in_data.normal_x;
                                r_yb[1] <= i_in_data.normal_y;
                                r_yb[2] <= i_in_data.normal_z;
                                r_bnd   <= r_bnd || i_in_data.on_boundary;
                                r_flat  <= 1'b0;
                                r_k     <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    r_off[i] <= '0;
                                end
                                // A boundary neighbor suppresses the segment.
                                if (!(r_bnd || i_in_data.on_boundary)) begin
                                    r_state <= S_MOD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= '0;
                        r_state <= (div_rem == '0) ? S_DOTX : S_IDLE;
                    end
                end
                S_DOTX, S_DOTY: begin
                    if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= acc_n;
                        r_k    <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_acc <= '0;
                            r_k   <= '0;
                            for (int i = 0; i < 3; i++) begin
                                if (r_state == S_DOTX) begin
                                    r_xbf[i] <= acc_n[ACC_W-1] ? -17'(r_xb[i]) : 17'(r_xb[i]);
                                    r_nx[i]  <= 18'(r_xf[i]) - (acc_n[ACC_W-1] ?
                                                -18'(r_xb[i]) : 18'(r_xb[i]));
                                end else begin
                                    r_ybf[i] <= acc_n[ACC_W-1] ? -17'(r_yb[i]) : 17'(r_yb[i]);
                                    r_ny[i]  <= 18'(r_yf[i]) - (acc_n[ACC_W-1] ?
                                                -18'(r_yb[i]) : 18'(r_yb[i]));
                                end
                            end
                            r_state <= (r_state == S_DOTX) ? S_DOTY : S_NRM;
                        end
                    end
                end
                S_NRM: begin
                    if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= acc_n;
                        r_k    <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_fx  <= acc_n < t2;
                            r_acc <= '0;
                        end else if (r_k == 3'd5) begin
                            r_acc <= '0;
                            r_k   <= '0;
                            if (r_fx && (acc_n < t2)) begin
                                r_flat  <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_DOTNN;
                            end
                        end
                    end
                end
                S_DOTNN: begin
                    if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= acc_n;
                        r_k    <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_acc <= '0;
                            r_k   <= '0;
                            if (acc_n[ACC_W-1]) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_ny[i] <= -r_ny[i];
                                end
                            end
                            r_state <= S_CROSS;
                        end
                    end
                end
                S_CROSS: begin
                    if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= acc_n;
                        r_k    <= r_k + 1'b1;
                        if (r_k[0]) begin
                            r_c[r_k[2:1]] <= 35'(acc_n);
                            r_acc         <= '0;
                        end
                        if (r_k == 3'd5) begin
                            r_k     <= '0;
                            r_state <= S_SQC;
                        end
                    end
                end
                S_SQC: begin
                    // A zero cross product leaves the ruling at zero.
                    if (!r_pend && c_zero && (r_k == 3'd0)) begin
                        r_state <= S_OUT;
                    end else if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= acc_n;
                        r_k    <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_state <= S_SQRTC;
                        end
                    end
                end
                S_SQRTC: begin
                    if (u_done) begin
                        r_pend  <= 1'b0;
                        r_cl    <= sq_root;
                        r_acc   <= '0;
                        r_state <= S_SQE;
                    end
                end
                S_SQE: begin
                    if (u_done) begin
                        r_pend <= 1'b0;
                        r_acc  <= acc_n;
                        r_k    <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_state <= S_SQRTE;
                        end
                    end
                end
                S_SQRTE: begin
                    if (u_done) begin
                        r_pend  <= 1'b0;
                        r_el    <= sq_root;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (u_done) begin
                        r_pend  <= 1'b0;
                        r_scale <= 42'(mul_p >>> 8);
                        r_state <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (u_done) begin
                        r_pend        <= 1'b0;
                        r_r[r_k[1:0]] <= div_quo;
                        r_k           <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_state <= S_OFF;
                        end
                    end
                end
                S_OFF: begin
                    if (u_done) begin
                        r_pend          <= 1'b0;
                        r_off[r_k[1:0]] <= r_c[r_k[1:0]][34] ? -om : om;
                        r_k             <= r_k + 1'b1;
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.start_x <= f_sat(45'(r_cp[0]) - 45'(r_off[0]));
                        r_out.start_y <= f_sat(45'(r_cp[1]) - 45'(r_off[1]));
                        r_out.start_z <= f_sat(45'(r_cp[2]) - 45'(r_off[2]));
                        r_out.end_x   <= f_sat(45'(r_cp[0]) + 45'(r_off[0]));
                        r_out.end_y   <= f_sat(45'(r_cp[1]) + 45'(r_off[1]));
                        r_out.end_z   <= f_sat(45'(r_cp[2]) + 45'(r_off[2]));
                        r_out.flat    <= r_flat;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/srs_checker.sv]
`timescale 1ns / 1ps
module srs_checker import srs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_beat    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_beat   o_out_data
);

    // A result waiting at the output holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // A new result is only produced by the sequencer, never from idle.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a busy computation");

    // A flat star carries no offset.
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.flat |->
            o_out_data.start_x == o_out_data.end_x &&
            o_out_data.start_y == o_out_data.end_y &&
            o_out_data.start_z == o_out_data.end_z)
        else $error("flat result with nonzero offset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready dropped");

endmodule

bind surface_ruling_segment srs_checker u_srs_checker (.*);
